### hdl/gdb_pkg.sv
// Shared types and codes of the graph walk engine.
package gdb_pkg;

  localparam int VTX_W  = 6;   // vertex field width
  localparam int PTR_W  = 13;  // widest slot pointer (slot index plus end-of-list bit)
  localparam int MARK_W = 2;
  localparam int VCNT_W = 7;

  localparam logic [2:0] MODE_DIRECTED   = 3'd0;
  localparam logic [2:0] MODE_UNDIRECTED = 3'd1;
  localparam logic [2:0] MODE_CLEAR      = 3'd2;
  localparam logic [2:0] MODE_WALK       = 3'd3;
  localparam logic [2:0] MODE_BIPARTITE  = 3'd4;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CLEARED   = 3'd2,
    KIND_VISITED   = 3'd3,
    KIND_BIPARTITE = 3'd4,
    KIND_BAD_START = 3'd5
  } kind_e;

  typedef struct packed {
    logic [VTX_W-1:0]  head_addr;
    logic              head_wr;
    logic [PTR_W-1:0]  head_wdata;
    logic              graph_clr;
    logic [VTX_W-1:0]  tail_addr;
    logic              tail_wr;
    logic [PTR_W-1:0]  tail_wdata;
    logic [PTR_W-1:0]  slot_addr;
    logic              tgt_wr;
    logic [VTX_W-1:0]  tgt_wdata;
    logic              nxt_wr;
    logic [PTR_W-1:0]  nxt_wdata;
    logic [VTX_W-1:0]  mark_addr;
    logic              mark_wr;
    logic              mark_clr;
    logic [MARK_W-1:0] mark_wdata;
    logic [VTX_W-1:0]  stk_addr;
    logic              stk_wr;
    logic [PTR_W-1:0]  stk_wdata;
    logic              slots_inc;
    logic              count_inc;
  } cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0]  head_data;
    logic [PTR_W-1:0]  tail_data;
    logic [VTX_W-1:0]  tgt_data;
    logic [PTR_W-1:0]  nxt_data;
    logic [MARK_W-1:0] mark_data;
    logic [PTR_W-1:0]  stk_data;
    logic [PTR_W-1:0]  slots;
    logic [VCNT_W-1:0] vcount;
  } status_t;

endpackage

### hdl/gdb_datapath.sv
// Datapath: list, edge, mark and stack memories plus the edge counters.
module gdb_datapath #(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_SLOTS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  gdb_pkg::cmd_t        cmd_i,
  output gdb_pkg::status_t     status_o,
  output logic [8:0]           edge_total_o
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int SW   = $clog2(MAX_EDGE_SLOTS);
  localparam int PW   = SW + 1;
  localparam int PtrW = gdb_pkg::PTR_W;
  localparam logic [PW-1:0] Nil = PW'(MAX_EDGE_SLOTS);

  logic [PW-1:0] head_mem [MAX_VERTICES];
  logic [SW-1:0] tail_mem [MAX_VERTICES];
  logic [5:0]    tgt_mem  [MAX_EDGE_SLOTS];
  logic [PW-1:0] nxt_mem  [MAX_EDGE_SLOTS];
  logic [1:0]    mark_mem [MAX_VERTICES];
  logic [PW-1:0] stk_mem  [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] head_vld_q, mark_vld_q, mark_vld_d;
  logic [PW-1:0] slots_q, count_q;
  logic [6:0]    vcount_q, vcount_d;

  logic [PW-1:0] head_rd_q, nxt_rd_q, stk_rd_q;
  logic [SW-1:0] tail_rd_q;
  logic [5:0]    tgt_rd_q;
  logic [1:0]    mark_rd_q;

  logic [VW-1:0] head_a, tail_a, mark_a, stk_a;
  logic [SW-1:0] slot_a;

  assign head_a = cmd_i.head_addr[VW-1:0];
  assign tail_a = cmd_i.tail_addr[VW-1:0];
  assign mark_a = cmd_i.mark_addr[VW-1:0];
  assign stk_a  = cmd_i.stk_addr[VW-1:0];
  assign slot_a = cmd_i.slot_addr[SW-1:0];

  // clamp written vertex count into 1..MAX_VERTICES
  always_comb begin
    vcount_d = cfg_wdata_i;
    if (cfg_wdata_i == 7'd0) begin
      vcount_d = 7'd1;
    end else if (cfg_wdata_i > 7'(MAX_VERTICES)) begin
      vcount_d = 7'(MAX_VERTICES);
    end
  end

  // mark valid bits: a clear and a write may land together at walk start
  always_comb begin
    mark_vld_d = mark_vld_q;
    if (cmd_i.mark_clr) mark_vld_d = '0;
    if (cmd_i.mark_wr) mark_vld_d[mark_a] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      mark_vld_q <= '0;
      slots_q    <= '0;
      count_q    <= '0;
      vcount_q   <= 7'(MAX_VERTICES);
    end else begin
      if (cfg_we_i) vcount_q <= vcount_d;
      if (cmd_i.graph_clr) begin
        head_vld_q <= '0;
        slots_q    <= '0;
        count_q    <= '0;
      end else begin
        if (cmd_i.head_wr) head_vld_q[head_a] <= 1'b1;
        if (cmd_i.slots_inc) slots_q <= slots_q + PW'(1);
        if (cmd_i.count_inc) count_q <= count_q + PW'(1);
      end
      mark_vld_q <= mark_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_wr) head_mem[head_a] <= cmd_i.head_wdata[PW-1:0];
    if (cmd_i.tail_wr) tail_mem[tail_a] <= cmd_i.tail_wdata[SW-1:0];
    if (cmd_i.tgt_wr)  tgt_mem[slot_a]  <= cmd_i.tgt_wdata;
    if (cmd_i.nxt_wr)  nxt_mem[slot_a]  <= cmd_i.nxt_wdata[PW-1:0];
    if (cmd_i.mark_wr) mark_mem[mark_a] <= cmd_i.mark_wdata;
    if (cmd_i.stk_wr)  stk_mem[stk_a]   <= cmd_i.stk_wdata[PW-1:0];
    head_rd_q <= head_vld_q[head_a] ? head_mem[head_a] : Nil;
    mark_rd_q <= mark_vld_q[mark_a] ? mark_mem[mark_a] : 2'd0;
    tail_rd_q <= tail_mem[tail_a];
    tgt_rd_q  <= tgt_mem[slot_a];
    nxt_rd_q  <= nxt_mem[slot_a];
    stk_rd_q  <= stk_mem[stk_a];
  end

  always_comb begin
    status_o.head_data = PtrW'(head_rd_q);
    status_o.tail_data = PtrW'(tail_rd_q);
    status_o.tgt_data  = tgt_rd_q;
    status_o.nxt_data  = PtrW'(nxt_rd_q);
    status_o.mark_data = mark_rd_q;
    status_o.stk_data  = PtrW'(stk_rd_q);
    status_o.slots     = PtrW'(slots_q);
    status_o.vcount    = vcount_q;
  end

  assign edge_total_o = 9'(count_q);

endmodule

### hdl/gdb_ctrl.sv
// Controller: sequencer for edge append, depth walk and two-colouring.
module gdb_ctrl #(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_SLOTS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        mode_i,
  input  logic [5:0]        from_vertex_i,
  input  logic [5:0]        to_vertex_i,
  input  gdb_pkg::status_t  status_i,
  output gdb_pkg::cmd_t     cmd_o,
  output logic              busy_o,
  output logic              valid_o,
  output logic [2:0]        kind_o,
  output logic [5:0]        vertex_o,
  output logic              is_bipartite_o,
  output logic              last_o
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int PW   = $clog2(MAX_EDGE_SLOTS) + 1;
  localparam int PtrW = gdb_pkg::PTR_W;
  localparam logic [PW-1:0] Nil = PW'(MAX_EDGE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_A1, S_A2, S_W_HEAD, S_W_STEP, S_W_POP, S_W_EDGE, S_W_MARK,
    S_B_V, S_B_VH, S_B_P, S_B_E, S_B_T, S_B_F, S_B_FC
  } state_e;

  state_e        state_q, state_d;
  logic [VW:0]   sp_q, sp_d;
  logic [6:0]    v_q, v_d;
  logic [PW-1:0] p_q, p_d;
  logic [5:0]    t_q, t_d, a_q, a_d, b_q, b_d, pend_q, pend_d;
  logic [1:0]    mv_q, mv_d;
  logic          ok_q, ok_d, chg_q, chg_d, undir_q, undir_d, ph_q, ph_d;
  logic          valid_q, valid_d, bip_q, bip_d, last_q, last_d;
  gdb_pkg::kind_e kind_q, kind_d;
  logic [5:0]    vtx_q, vtx_d;

  logic [6:0]    vcnt;
  logic [PW-1:0] slots, head_p, nxt_p, stk_p;
  logic [PW:0]   room;
  logic [5:0]    src, dst, tgt;

  assign vcnt   = status_i.vcount;
  assign slots  = status_i.slots[PW-1:0];
  assign head_p = status_i.head_data[PW-1:0];
  assign nxt_p  = status_i.nxt_data[PW-1:0];
  assign stk_p  = status_i.stk_data[PW-1:0];
  assign tgt    = status_i.tgt_data;
  assign src    = ph_q ? b_q : a_q;
  assign dst    = ph_q ? a_q : b_q;
  assign room   = {1'b0, slots} + ((mode_i == gdb_pkg::MODE_UNDIRECTED) ? (PW+1)'(2)
                                                                         : (PW+1)'(1));

  always_comb begin
    state_d = state_q; sp_d = sp_q; v_d = v_q; p_d = p_q; t_d = t_q;
    a_d = a_q; b_d = b_q; pend_d = pend_q; mv_d = mv_q; ok_d = ok_q;
    chg_d = chg_q; undir_d = undir_q; ph_d = ph_q;
    valid_d = 1'b0; kind_d = kind_q; vtx_d = 6'd0; bip_d = 1'b0; last_d = 1'b0;
    cmd_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            gdb_pkg::MODE_DIRECTED, gdb_pkg::MODE_UNDIRECTED: begin
              if ({1'b0, from_vertex_i} >= vcnt || {1'b0, to_vertex_i} >= vcnt ||
                  room > (PW+1)'(MAX_EDGE_SLOTS)) begin
                valid_d = 1'b1; kind_d = gdb_pkg::KIND_REJECTED; last_d = 1'b1;
              end else begin
                a_d = from_vertex_i; b_d = to_vertex_i; ph_d = 1'b0;
                undir_d = (mode_i == gdb_pkg::MODE_UNDIRECTED);
                state_d = S_A1;
              end
            end
            gdb_pkg::MODE_CLEAR: begin
              cmd_o.graph_clr = 1'b1;
              valid_d = 1'b1; kind_d = gdb_pkg::KIND_CLEARED; last_d = 1'b1;
            end
            gdb_pkg::MODE_WALK: begin
              if ({1'b0, from_vertex_i} >= vcnt) begin
                valid_d = 1'b1; kind_d = gdb_pkg::KIND_BAD_START; last_d = 1'b1;
              end else begin
                cmd_o.mark_clr   = 1'b1;
                cmd_o.mark_wr    = 1'b1;
                cmd_o.mark_addr  = from_vertex_i;
                cmd_o.mark_wdata = 2'd1;
                cmd_o.head_addr  = from_vertex_i;
                pend_d  = from_vertex_i;
                sp_d    = (VW+1)'(1);
                state_d = S_W_HEAD;
              end
            end
            gdb_pkg::MODE_BIPARTITE: begin
              cmd_o.mark_clr = 1'b1;
              ok_d = 1'b1; chg_d = 1'b0; v_d = 7'd0;
              state_d = S_B_V;
            end
            default: ;
          endcase
        end
      end
      // append: write slot, fetch head and tail of the source list
      S_A1: begin
        cmd_o.head_addr = src;
        cmd_o.tail_addr = src;
        cmd_o.slot_addr = PtrW'(slots);
        cmd_o.tgt_wr    = 1'b1;
        cmd_o.tgt_wdata = dst;
        cmd_o.nxt_wr    = 1'b1;
        cmd_o.nxt_wdata = PtrW'(Nil);
        state_d = S_A2;
      end
      // append: link slot to list
      S_A2: begin
        cmd_o.head_addr = src;
        cmd_o.tail_addr = src;
        if (head_p >= Nil) begin
          cmd_o.head_wr    = 1'b1;
          cmd_o.head_wdata = PtrW'(slots);
        end else begin
          cmd_o.slot_addr = status_i.tail_data;
          cmd_o.nxt_wr    = 1'b1;
          cmd_o.nxt_wdata = PtrW'(slots);
        end
        cmd_o.tail_wr    = 1'b1;
        cmd_o.tail_wdata = PtrW'(slots);
        cmd_o.slots_inc  = 1'b1;
        if (undir_q && !ph_q) begin
          ph_d = 1'b1; state_d = S_A1;
        end else begin
          cmd_o.count_inc = 1'b1;
          valid_d = 1'b1; kind_d = gdb_pkg::KIND_ADDED; last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_W_HEAD: begin
        p_d = head_p; state_d = S_W_STEP;
      end
      S_W_STEP: begin
        if (p_q >= Nil) begin
          if (sp_q == (VW+1)'(1)) begin
            valid_d = 1'b1; kind_d = gdb_pkg::KIND_VISITED; vtx_d = pend_q; last_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.stk_addr = 6'(sp_q - (VW+1)'(2));
            sp_d    = sp_q - (VW+1)'(1);
            state_d = S_W_POP;
          end
        end else begin
          cmd_o.slot_addr = PtrW'(p_q);
          state_d = S_W_EDGE;
        end
      end
      S_W_POP: begin
        p_d = stk_p; state_d = S_W_STEP;
      end
      S_W_EDGE: begin
        p_d = nxt_p;
        if ({1'b0, tgt} >= vcnt) begin
          state_d = S_W_STEP;
        end else begin
          cmd_o.mark_addr = tgt; t_d = tgt; state_d = S_W_MARK;
        end
      end
      S_W_MARK: begin
        if (status_i.mark_data == 2'd0 && sp_q < (VW+1)'(MAX_VERTICES)) begin
          cmd_o.mark_addr  = t_q;
          cmd_o.mark_wr    = 1'b1;
          cmd_o.mark_wdata = 2'd1;
          cmd_o.stk_addr   = 6'(sp_q - (VW+1)'(1));
          cmd_o.stk_wr     = 1'b1;
          cmd_o.stk_wdata  = PtrW'(p_q);
          cmd_o.head_addr  = t_q;
          valid_d = 1'b1; kind_d = gdb_pkg::KIND_VISITED; vtx_d = pend_q;
          pend_d  = t_q;
          sp_d    = sp_q + (VW+1)'(1);
          state_d = S_W_HEAD;
        end else begin
          state_d = S_W_STEP;
        end
      end
      S_B_V: begin
        if (v_q == vcnt) begin
          v_d = 7'd0;
          if (!chg_q) state_d = S_B_F;
          else chg_d = 1'b0;
        end else begin
          cmd_o.head_addr = 6'(v_q);
          cmd_o.mark_addr = 6'(v_q);
          state_d = S_B_VH;
        end
      end
      S_B_VH: begin
        p_d = head_p; mv_d = status_i.mark_data; state_d = S_B_P;
      end
      S_B_P: begin
        if (p_q >= Nil) begin
          v_d = v_q + 7'd1; state_d = S_B_V;
        end else begin
          cmd_o.slot_addr = PtrW'(p_q); state_d = S_B_E;
        end
      end
      S_B_E: begin
        p_d = nxt_p;
        if ({1'b0, tgt} >= vcnt) begin
          state_d = S_B_P;
        end else begin
          cmd_o.mark_addr = tgt; t_d = tgt; state_d = S_B_T;
        end
      end
      // colour propagation across one edge
      S_B_T: begin
        state_d = S_B_P;
        priority if (mv_q != 2'd0 && status_i.mark_data != 2'd0) begin
          if (mv_q == status_i.mark_data) ok_d = 1'b0;
        end else if (mv_q != 2'd0) begin
          cmd_o.mark_addr  = t_q;
          cmd_o.mark_wr    = 1'b1;
          cmd_o.mark_wdata = 2'd3 - mv_q;
          chg_d = 1'b1;
        end else if (status_i.mark_data != 2'd0) begin
          cmd_o.mark_addr  = 6'(v_q);
          cmd_o.mark_wr    = 1'b1;
          cmd_o.mark_wdata = 2'd3 - status_i.mark_data;
          mv_d  = 2'd3 - status_i.mark_data;
          chg_d = 1'b1;
        end else begin
        end
      end
      S_B_F: begin
        if (v_q == vcnt) begin
          valid_d = 1'b1; kind_d = gdb_pkg::KIND_BIPARTITE; bip_d = ok_q; last_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.mark_addr = 6'(v_q); state_d = S_B_FC;
        end
      end
      S_B_FC: begin
        if (status_i.mark_data == 2'd0) begin
          cmd_o.mark_addr  = 6'(v_q);
          cmd_o.mark_wr    = 1'b1;
          cmd_o.mark_wdata = 2'd1;
          chg_d = 1'b0; v_d = 7'd0;
          state_d = S_B_V;
        end else begin
          v_d = v_q + 7'd1; state_d = S_B_F;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      kind_q  <= gdb_pkg::KIND_ADDED;
      vtx_q   <= '0;
      bip_q   <= 1'b0;
      last_q  <= 1'b0;
      sp_q    <= '0;
      v_q     <= '0;
      ph_q    <= 1'b0;
      undir_q <= 1'b0;
      ok_q    <= 1'b0;
      chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      kind_q  <= kind_d;
      vtx_q   <= vtx_d;
      bip_q   <= bip_d;
      last_q  <= last_d;
      sp_q    <= sp_d;
      v_q     <= v_d;
      ph_q    <= ph_d;
      undir_q <= undir_d;
      ok_q    <= ok_d;
      chg_q   <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t_q    <= t_d;
    a_q    <= a_d;
    b_q    <= b_d;
    pend_q <= pend_d;
    mv_q   <= mv_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign kind_o         = kind_q;
  assign vertex_o       = vtx_q;
  assign is_bipartite_o = bip_q;
  assign last_o         = last_q;

endmodule

### hdl/graph_dfs_bipartite_engine.sv
// Top level of the graph store with depth-first walk and bipartite check.
//
//  channel  | handshake          | words
//  ---------+--------------------+-----------------------------------------------
//  command  | start_i && !busy_o | mode_i, from_vertex_i, to_vertex_i
//  result   | valid_o (1 cycle)  | kind_o, vertex_o, is_bipartite_o,
//           |                    | edge_total_o, last_o
//  config   | cfg_we_i           | cfg_wdata_i (vertex count)
//
// A directed edge passes through the append states once, an undirected one twice
// (two slot appends through the single-port list memories); clear and rejects are
// answered from idle without going busy. A walk moves through head, step, edge and
// pop states, with a mark read for each edge whose target is in range; the bipartite
// check repeats passes over all vertices and edges until no colour changes, then
// sweeps for an uncoloured vertex, all bounded by the registered memory reads.
// Reset empties every list at once through per-vertex valid bits; no sweep.
// Each result word shows in the cycle after its cause; the receiver cannot stall,
// and a new command may be taken in the cycle a final result is shown.
module graph_dfs_bipartite_engine #(
  parameter int MAX_VERTICES   = 64,
  parameter int MAX_EDGE_SLOTS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] mode_i,
  input  logic [5:0] from_vertex_i,
  input  logic [5:0] to_vertex_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output logic       valid_o,
  output logic [2:0] kind_o,
  output logic [5:0] vertex_o,
  output logic       is_bipartite_o,
  output logic [8:0] edge_total_o,
  output logic       last_o
);

  gdb_pkg::cmd_t    cmd;
  gdb_pkg::status_t status;

  // sequencer: owns the walk stack pointer, colour bookkeeping and result word
  gdb_ctrl #(
    .MAX_VERTICES   (MAX_VERTICES),
    .MAX_EDGE_SLOTS (MAX_EDGE_SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .mode_i         (mode_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .vertex_o       (vertex_o),
    .is_bipartite_o (is_bipartite_o),
    .last_o         (last_o)
  );

  // storage: lists, edge slots, marks, stack; edge counters and vertex count
  gdb_datapath #(
    .MAX_VERTICES   (MAX_VERTICES),
    .MAX_EDGE_SLOTS (MAX_EDGE_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .edge_total_o (edge_total_o)
  );

endmodule

### hdl/gdb_checker.sv
// Port-level checker for the graph walk engine, bound to the top level.
module gdb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] mode_i,
  input logic       valid_o,
  input logic [2:0] kind_o,
  input logic [5:0] vertex_o,
  input logic       is_bipartite_o,
  input logic [8:0] edge_total_o,
  input logic       last_o
);

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == gdb_pkg::MODE_CLEAR) |=>
      (valid_o && kind_o == gdb_pkg::KIND_CLEARED && edge_total_o == 9'd0 && last_o))
    else $error("clear did not report an empty graph");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o != gdb_pkg::KIND_VISITED) |-> last_o)
    else $error("single-word result without last");

  a_vertex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o != gdb_pkg::KIND_VISITED) |-> (vertex_o == 6'd0))
    else $error("vertex set on non-walk result");

  a_bip_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o != gdb_pkg::KIND_BIPARTITE) |-> !is_bipartite_o)
    else $error("bipartite flag on wrong result");

  a_busy_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o)
    else $error("walk word mid-stream while idle");

endmodule

bind graph_dfs_bipartite_engine gdb_checker u_gdb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .mode_i         (mode_i),
  .valid_o        (valid_o),
  .kind_o         (kind_o),
  .vertex_o       (vertex_o),
  .is_bipartite_o (is_bipartite_o),
  .edge_total_o   (edge_total_o),
  .last_o         (last_o)
);
